@@ rtl/mfst_pkg.sv @@
`timescale 1ns / 1ps
package mfst_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NEW      = 3'd2;
  localparam logic [2:0] ST_RAISED   = 3'd3;
  localparam logic [2:0] ST_KEPT     = 3'd4;
  localparam logic [2:0] ST_READ_OK  = 3'd5;
  localparam logic [2:0] ST_NO_ENTRY = 3'd6;

  localparam logic [7:0]  TYPE_BEACON    = 8'h80;
  localparam logic [7:0]  TYPE_PROBE     = 8'h40;
  localparam logic [11:0] MIN_FRAME_LEN  = 12'd40;
  localparam logic [11:0] LEN_POS_BEACON = 12'd37;
  localparam logic [11:0] LEN_POS_PROBE  = 12'd25;
  localparam logic [11:0] MAC_FIRST      = 12'd10;
  localparam logic [11:0] MAC_LAST       = 12'd15;
  localparam logic [11:0] POS_MAX        = 12'hFFF;
  localparam logic [7:0]  PRINT_LO       = 8'h20;
  localparam logic [7:0]  PRINT_HI       = 8'h7E;
  localparam logic [7:0]  QMARK          = 8'h3F;

  // table row layout: kind, mac, channel, rssi, ssid length, then ssid bytes
  localparam int ROW_KIND = 0;
  localparam int ROW_MAC  = 1;
  localparam int ROW_CH   = 49;
  localparam int ROW_RSSI = 53;
  localparam int ROW_LEN  = 61;
  localparam int ROW_SSID = 67;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic clear_tbl;
    logic read_req;
    logic check;
    logic rd_issue;
    logic walk_next;
    logic hit;
    logic add;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] opcode;
    logic       last;
    logic       pass;
    logic       empty;
    logic       hit;
    logic       walk_last;
    logic       out_free;
  } stat_t;

endpackage

@@ rtl/mfst_req_if.sv @@
`timescale 1ns / 1ps
interface mfst_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              frame_is_mgmt;
  logic [11:0]       signal_length;
  logic [3:0]        rx_channel;
  logic signed [7:0] rx_rssi;
  logic [5:0]        read_index;
  logic [4:0]        read_ssid_pos;

  modport source (output valid, opcode, data_byte, last_byte, frame_is_mgmt, signal_length,
                  rx_channel, rx_rssi, read_index, read_ssid_pos, input ready);
  modport sink (input valid, opcode, data_byte, last_byte, frame_is_mgmt, signal_length,
                rx_channel, rx_rssi, read_index, read_ssid_pos, output ready);
endinterface

@@ rtl/mfst_rsp_if.sv @@
`timescale 1ns / 1ps
interface mfst_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [5:0]        entry_slot;
  logic [6:0]        entry_total;
  logic              frame_kind;
  logic [47:0]       source_mac;
  logic [3:0]        entry_channel;
  logic signed [7:0] entry_rssi;
  logic [5:0]        ssid_length;
  logic [7:0]        ssid_byte;

  modport source (output valid, status, entry_slot, entry_total, frame_kind, source_mac,
                  entry_channel, entry_rssi, ssid_length, ssid_byte, input ready);
  modport sink (input valid, status, entry_slot, entry_total, frame_kind, source_mac,
                entry_channel, entry_rssi, ssid_length, ssid_byte, output ready);
endinterface

@@ rtl/mfst_ram.sv @@
`timescale 1ns / 1ps
module mfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/mfst_ctrl.sv @@
`timescale 1ns / 1ps
module mfst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  mfst_pkg::stat_t st,
  output mfst_pkg::cmd_t  cmd
);
  import mfst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_RD    = 5'b00100,
    S_CMP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = st.in_valid && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (accept) begin
          case (op_t'(st.opcode))
            OP_BYTE: begin
              cmd.capture = 1'b1;
              if (st.last) state_next = S_CHECK;
            end
            OP_CLEAR: cmd.clear_tbl = 1'b1;
            OP_READ: begin
              cmd.read_req = 1'b1;
              state_next   = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!st.pass) begin
          state_next = S_DONE;
        end else if (st.empty) begin
          cmd.add    = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        if (st.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else if (st.walk_last) begin
          cmd.add    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.walk_next = 1'b1;
          state_next    = S_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

@@ rtl/mfst_dp.sv @@
`timescale 1ns / 1ps
module mfst_dp #(
  parameter int MAX_ENTRIES  = 64,
  parameter int MAX_SSID_LEN = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_en,
  input  logic            cfg_write_data,
  mfst_req_if.sink        req,
  mfst_rsp_if.source      rsp,
  input  mfst_pkg::cmd_t  cmd,
  output mfst_pkg::stat_t st
);
  import mfst_pkg::*;

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMPW = CW + 6;
  localparam int RW   = ROW_SSID + 8 * MAX_SSID_LEN;

  logic              scan_active;
  logic [CW-1:0]     entry_count;
  logic [11:0]       byte_position;
  logic [7:0]        frame_type_byte;
  logic [47:0]       frame_mac;
  logic [5:0]        frame_ssid_len;
  logic [7:0]        frame_ssid [MAX_SSID_LEN];
  logic              m_mgmt;
  logic [11:0]       m_len;
  logic [3:0]        m_ch;
  logic signed [7:0] m_rs;
  logic [4:0]        rd_pos;
  logic [IW-1:0]     walk_idx;
  logic [2:0]        res_status;
  logic [5:0]        res_slot;
  logic              res_frame;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [RW-1:0]     ram_wdata, rd_data, new_row, upd_row;

  logic              known;
  logic [11:0]       len_at, ssid_base, ssid_off;
  logic [7:0]        clean_byte;
  logic              kind_probe, type_ok, raise, ssid_eq;
  logic [7:0]        sel_byte;
  logic signed [7:0] stored_rs;

  assign req.ready    = cmd.in_ready;
  assign st.in_valid  = req.valid;
  assign st.opcode    = req.opcode;
  assign st.last      = req.last_byte;
  assign st.out_free  = !rsp.valid || rsp.ready;
  assign st.empty     = (entry_count == '0);
  assign st.walk_last = ((CW'(walk_idx) + CW'(1)) == entry_count);

  // byte capture decode
  always_comb begin
    known  = 1'b0;
    len_at = '0;
    if (byte_position != '0 && frame_type_byte == TYPE_BEACON) begin
      known  = 1'b1;
      len_at = LEN_POS_BEACON;
    end
    if (byte_position != '0 && frame_type_byte == TYPE_PROBE) begin
      known  = 1'b1;
      len_at = LEN_POS_PROBE;
    end
    ssid_base  = len_at + 12'd1;
    ssid_off   = byte_position - ssid_base;
    clean_byte = (req.data_byte >= PRINT_LO && req.data_byte <= PRINT_HI) ? req.data_byte
                                                                          : QMARK;
  end

  assign kind_probe = (frame_type_byte == TYPE_PROBE);
  assign type_ok    = (frame_type_byte == TYPE_BEACON) || kind_probe;
  assign st.pass    = m_mgmt && scan_active && (entry_count < CW'(MAX_ENTRIES)) && type_ok &&
                      (m_len >= MIN_FRAME_LEN);

  // compare the row under the walk against the captured frame
  always_comb begin
    ssid_eq = 1'b1;
    for (int j = 0; j < MAX_SSID_LEN; j++) begin
      if (6'(j) < frame_ssid_len && rd_data[ROW_SSID + 8*j +: 8] != frame_ssid[j]) begin
        ssid_eq = 1'b0;
      end
    end
  end
  assign st.hit = (rd_data[ROW_KIND] == kind_probe) &&
                  (rd_data[ROW_MAC +: 48] == frame_mac) &&
                  (rd_data[ROW_LEN +: 6] == frame_ssid_len) && ssid_eq;

  assign stored_rs = $signed(rd_data[ROW_RSSI +: 8]);
  assign raise     = (m_rs > stored_rs);

  always_comb begin
    new_row                 = '0;
    new_row[ROW_KIND]       = kind_probe;
    new_row[ROW_MAC +: 48]  = frame_mac;
    new_row[ROW_CH +: 4]    = m_ch;
    new_row[ROW_RSSI +: 8]  = m_rs;
    new_row[ROW_LEN +: 6]   = frame_ssid_len;
    for (int j = 0; j < MAX_SSID_LEN; j++) begin
      new_row[ROW_SSID + 8*j +: 8] = frame_ssid[j];
    end
    upd_row                = rd_data;
    upd_row[ROW_RSSI +: 8] = m_rs;
  end

  always_comb begin
    sel_byte = '0;
    for (int j = 0; j < MAX_SSID_LEN; j++) begin
      if (rd_pos == 5'(j)) sel_byte = rd_data[ROW_SSID + 8*j +: 8];
    end
    if (6'(rd_pos) >= rd_data[ROW_LEN +: 6]) sel_byte = '0;
  end

  assign ram_we    = cmd.add || (cmd.hit && raise);
  assign ram_waddr = cmd.add ? IW'(entry_count) : walk_idx;
  assign ram_wdata = cmd.add ? new_row : upd_row;
  assign ram_re    = cmd.read_req || cmd.rd_issue;
  assign ram_raddr = cmd.read_req ? IW'(req.read_index) : walk_idx;

  mfst_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // config, table count, frame capture
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active     <= 1'b0;
      entry_count     <= '0;
      byte_position   <= '0;
      frame_type_byte <= '0;
      frame_mac       <= '0;
      frame_ssid_len  <= '0;
      for (int j = 0; j < MAX_SSID_LEN; j++) frame_ssid[j] <= QMARK;
      rsp.valid       <= 1'b0;
    end else begin
      if (cfg_write_en) scan_active <= cfg_write_data;
      if (cmd.clear_tbl) entry_count <= '0;
      else if (cmd.add)  entry_count <= entry_count + CW'(1);

      if (cmd.capture) begin
        if (byte_position == '0) frame_type_byte <= req.data_byte;
        if (byte_position >= MAC_FIRST && byte_position <= MAC_LAST) begin
          frame_mac <= {frame_mac[39:0], req.data_byte};
        end
        if (known) begin
          if (byte_position == len_at) begin
            frame_ssid_len <= (req.data_byte > 8'(MAX_SSID_LEN)) ? 6'(MAX_SSID_LEN)
                                                                : req.data_byte[5:0];
          end else if (byte_position >= ssid_base &&
                       byte_position < ssid_base + 12'(MAX_SSID_LEN)) begin
            for (int j = 0; j < MAX_SSID_LEN; j++) begin
              if (ssid_off == 12'(j)) frame_ssid[j] <= clean_byte;
            end
          end
        end
        if (byte_position != POS_MAX) byte_position <= byte_position + 12'd1;
      end

      if (cmd.load) begin
        rsp.valid <= 1'b1;
        if (res_frame) begin
          // end of frame: drop all capture state
          byte_position   <= '0;
          frame_type_byte <= '0;
          frame_mac       <= '0;
          frame_ssid_len  <= '0;
          for (int j = 0; j < MAX_SSID_LEN; j++) frame_ssid[j] <= QMARK;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // per item working registers
  always_ff @(posedge clk) begin
    if (cmd.capture && req.last_byte) begin
      m_mgmt <= req.frame_is_mgmt;
      m_len  <= req.signal_length;
      m_ch   <= req.rx_channel;
      m_rs   <= req.rx_rssi;
    end
    if (cmd.read_req) begin
      rd_pos     <= req.read_ssid_pos;
      res_slot   <= req.read_index;
      res_frame  <= 1'b0;
      res_status <= (CMPW'(req.read_index) < CMPW'(entry_count)) ? ST_READ_OK : ST_NO_ENTRY;
    end
    if (cmd.check) begin
      res_frame  <= 1'b1;
      walk_idx   <= '0;
      res_status <= (m_mgmt && scan_active && entry_count >= CW'(MAX_ENTRIES)) ? ST_FULL
                                                                              : ST_IGNORED;
      res_slot   <= '0;
    end
    if (cmd.walk_next) walk_idx <= walk_idx + IW'(1);
    if (cmd.hit) begin
      res_status <= raise ? ST_RAISED : ST_KEPT;
      res_slot   <= 6'(walk_idx);
    end
    if (cmd.add) begin
      res_status <= ST_NEW;
      res_slot   <= 6'(entry_count);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.status        <= res_status;
      rsp.entry_slot    <= res_slot;
      rsp.entry_total   <= 7'(entry_count);
      rsp.frame_kind    <= 1'b0;
      rsp.source_mac    <= '0;
      rsp.entry_channel <= '0;
      rsp.entry_rssi    <= '0;
      rsp.ssid_length   <= '0;
      rsp.ssid_byte     <= '0;
      case (res_status)
        ST_NEW: begin
          rsp.frame_kind    <= kind_probe;
          rsp.source_mac    <= frame_mac;
          rsp.entry_channel <= m_ch;
          rsp.entry_rssi    <= m_rs;
          rsp.ssid_length   <= frame_ssid_len;
        end
        ST_RAISED, ST_KEPT, ST_READ_OK: begin
          rsp.frame_kind    <= rd_data[ROW_KIND];
          rsp.source_mac    <= rd_data[ROW_MAC +: 48];
          rsp.entry_channel <= rd_data[ROW_CH +: 4];
          rsp.entry_rssi    <= (res_status == ST_RAISED) ? m_rs : stored_rs;
          rsp.ssid_length   <= rd_data[ROW_LEN +: 6];
          if (res_status == ST_READ_OK) rsp.ssid_byte <= sel_byte;
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES)) else $error("entry count past table size");
  a_add_room: assert property (@(posedge clk) disable iff (rst)
    cmd.add |-> entry_count < CW'(MAX_ENTRIES)) else $error("add into full table");
  a_hit_add: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit && cmd.add)) else $error("hit and add together");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp.valid) else $error("loaded result not presented");
endmodule

@@ rtl/mgmt_frame_sniff_table.sv @@
`timescale 1ns / 1ps
// Payload byte, clear and ignored opcodes are accepted back to back while the sequencer is idle.
// Frame end: capture, check, then a table read and a compare per stored entry compared
// (single read port of the entry table), then the result load once the output register is free.
// Read entry: registered table read, then result load.
// Reset (rst, synchronous, active high) empties the table, clears the frame
// capture registers and scan_active; table contents stay undefined.
module mgmt_frame_sniff_table #(
  parameter int MAX_ENTRIES  = 64,
  parameter int MAX_SSID_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  mfst_req_if.sink   req,
  mfst_rsp_if.source rsp
);
  import mfst_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Sequencer: accepts items in idle, walks the table at frame end, and
  // holds the result until the output register is free.
  mfst_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // Datapath: frame capture, entry table, compare and result register.
  mfst_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_SSID_LEN (MAX_SSID_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req),
    .rsp            (rsp),
    .cmd            (cmd),
    .st             (st)
  );
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import mfst_pkg::*;

  // Frame end walks the table with a read and a compare per stored entry.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [2:0]        status;
    logic [5:0]        entry_slot;
    logic [6:0]        entry_total;
    logic              frame_kind;
    logic [47:0]       source_mac;
    logic [3:0]        entry_channel;
    logic signed [7:0] entry_rssi;
    logic [5:0]        ssid_length;
    logic [7:0]        ssid_byte;
  } sniff_rsp_t;

  typedef struct packed {
    op_t               opcode;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic              frame_is_mgmt;
    logic [11:0]       signal_length;
    logic [3:0]        rx_channel;
    logic signed [7:0] rx_rssi;
    logic [5:0]        read_index;
    logic [4:0]        read_ssid_pos;
  } sniff_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic cfg_write_data = 1'b0;

  mfst_req_if req ();
  mfst_rsp_if rsp ();

  mgmt_frame_sniff_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req           (req.source),
    .rsp           (rsp.sink)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's table and frame capture registers.
  logic              scan_on;
  int                tbl_count;
  logic              tbl_kind [64];
  logic [47:0]       tbl_mac [64];
  logic [3:0]        tbl_chan [64];
  logic signed [7:0] tbl_rssi [64];
  logic [5:0]        tbl_slen [64];
  logic [7:0]        tbl_ssid [64][32];
  int                cur_pos;
  logic [7:0]        cur_type;
  logic [47:0]       cur_mac;
  logic [5:0]        cur_slen;
  logic [7:0]        cur_ssid [32];

  sniff_rsp_t pending_rsp [$];
  int  mismatches = 0;
  int  idle_pct = 13;
  int  watchdog = 0;
  logic timed_out = 1'b0;

  function automatic void frame_reset();
    cur_pos = 0;
    cur_type = '0;
    cur_mac = '0;
    cur_slen = '0;
    for (int k = 0; k < 32; k++) cur_ssid[k] = QMARK;
  endfunction

  function automatic sniff_rsp_t entry_rsp(logic [2:0] st, int idx, logic [7:0] sb);
    sniff_rsp_t r;
    r = '0;
    r.status = st;
    r.entry_slot = idx[5:0];
    r.entry_total = tbl_count[6:0];
    r.frame_kind = tbl_kind[idx];
    r.source_mac = tbl_mac[idx];
    r.entry_channel = tbl_chan[idx];
    r.entry_rssi = tbl_rssi[idx];
    r.ssid_length = tbl_slen[idx];
    r.ssid_byte = sb;
    return r;
  endfunction

  function automatic sniff_rsp_t bare_rsp(logic [2:0] st, logic [5:0] slot);
    sniff_rsp_t r;
    r = '0;
    r.status = st;
    r.entry_slot = slot;
    r.entry_total = tbl_count[6:0];
    return r;
  endfunction

  // Close out a frame: filter, dedup against the table, or append.
  function automatic sniff_rsp_t judge_frame(sniff_req_t it);
    logic kind;
    logic same;
    if (!it.frame_is_mgmt || !scan_on) return bare_rsp(ST_IGNORED, '0);
    if (tbl_count >= 64) return bare_rsp(ST_FULL, '0);
    if (cur_type != TYPE_BEACON && cur_type != TYPE_PROBE) return bare_rsp(ST_IGNORED, '0);
    if (it.signal_length < MIN_FRAME_LEN) return bare_rsp(ST_IGNORED, '0);
    kind = (cur_type == TYPE_PROBE);
    for (int i = 0; i < tbl_count; i++) begin
      same = tbl_kind[i] == kind && tbl_mac[i] == cur_mac && tbl_slen[i] == cur_slen;
      for (int k = 0; k < 32; k++)
        if (k < cur_slen && tbl_ssid[i][k] != cur_ssid[k]) same = 1'b0;
      if (same) begin
        if (it.rx_rssi > tbl_rssi[i]) begin
          tbl_rssi[i] = it.rx_rssi;
          return entry_rsp(ST_RAISED, i, '0);
        end
        return entry_rsp(ST_KEPT, i, '0);
      end
    end
    tbl_kind[tbl_count] = kind;
    tbl_mac[tbl_count] = cur_mac;
    tbl_chan[tbl_count] = it.rx_channel;
    tbl_rssi[tbl_count] = it.rx_rssi;
    tbl_slen[tbl_count] = cur_slen;
    for (int k = 0; k < 32; k++) tbl_ssid[tbl_count][k] = cur_ssid[k];
    tbl_count++;
    return entry_rsp(ST_NEW, tbl_count - 1, '0);
  endfunction

  // Advance the shadow state by one item; return 1 when a result is due.
  function automatic bit sniff_predict(sniff_req_t it, output sniff_rsp_t r);
    int lpos;
    logic [7:0] sb;
    r = '0;
    case (it.opcode)
      OP_BYTE: begin
        if (cur_pos == 0) cur_type = it.data_byte;
        if (cur_pos >= 10 && cur_pos <= 15) cur_mac = {cur_mac[39:0], it.data_byte};
        lpos = -1;
        if (cur_pos > 0 && cur_type == TYPE_BEACON) lpos = 37;
        if (cur_pos > 0 && cur_type == TYPE_PROBE) lpos = 25;
        if (lpos >= 0) begin
          if (cur_pos == lpos)
            cur_slen = (it.data_byte > 8'd32) ? 6'd32 : it.data_byte[5:0];
          else if (cur_pos > lpos && cur_pos <= lpos + 32)
            cur_ssid[cur_pos - lpos - 1] =
              (it.data_byte >= PRINT_LO && it.data_byte <= PRINT_HI) ? it.data_byte : QMARK;
        end
        if (cur_pos < 4095) cur_pos++;
        if (!it.last_byte) return 0;
        r = judge_frame(it);
        frame_reset();
        return 1;
      end
      OP_CLEAR: begin
        tbl_count = 0;
        return 0;
      end
      OP_READ: begin
        if (it.read_index < tbl_count) begin
          sb = (it.read_ssid_pos < tbl_slen[it.read_index]) ?
               tbl_ssid[it.read_index][it.read_ssid_pos] : 8'd0;
          r = entry_rsp(ST_READ_OK, it.read_index, sb);
        end else begin
          r = bare_rsp(ST_NO_ENTRY, it.read_index);
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Sink side: random stalls, compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        sniff_rsp_t got;
        sniff_rsp_t want;
        got = '{rsp.status, rsp.entry_slot, rsp.entry_total, rsp.frame_kind,
                rsp.source_mac, rsp.entry_channel, rsp.entry_rssi, rsp.ssid_length,
                rsp.ssid_byte};
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Hang detection: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold one item on the channel until accepted, with random idle gaps before it.
  // Valid stays high after the accepting edge; callers that pause drop it.
  task automatic send_item(sniff_req_t it, bit checked, sniff_rsp_t fixed);
    sniff_rsp_t r;
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= it.opcode;
    req.data_byte <= it.data_byte;
    req.last_byte <= it.last_byte;
    req.frame_is_mgmt <= it.frame_is_mgmt;
    req.signal_length <= it.signal_length;
    req.rx_channel <= it.rx_channel;
    req.rx_rssi <= it.rx_rssi;
    req.read_index <= it.read_index;
    req.read_ssid_pos <= it.read_ssid_pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (sniff_predict(it, r)) begin
      if (checked && r !== fixed) begin
        mismatches++;
        if (mismatches <= 10) $display("predictor disagrees with table row %p vs %p", fixed, r);
      end
      pending_rsp.push_back(r);
    end
  endtask

  function automatic sniff_req_t byte_item(logic [7:0] b, logic last);
    sniff_req_t it;
    it = '0;
    it.opcode = OP_BYTE;
    it.data_byte = b;
    it.last_byte = last;
    it.frame_is_mgmt = 1'b1;
    it.signal_length = 12'd100;
    it.rx_channel = 4'($urandom_range(15));
    it.rx_rssi = 8'($urandom_range(255));
    return it;
  endfunction

  // Drive one frame of n bytes; the SSID comes from a small pool so repeats occur.
  task automatic send_frame(int n, logic [7:0] ftype, logic [47:0] mac, int slen,
                            int ssid_seed);
    sniff_req_t it;
    sniff_rsp_t none;
    int lpos;
    none = '0;
    lpos = (ftype == TYPE_PROBE) ? 25 : 37;
    for (int p = 0; p < n; p++) begin
      it = byte_item(8'($urandom_range(255)), p == n - 1);
      if (p == 0) it.data_byte = ftype;
      if (p >= 10 && p <= 15) it.data_byte = mac[8 * (15 - p) +: 8];
      if (p == lpos) it.data_byte = 8'(slen);
      if (p > lpos) it.data_byte = 8'(((ssid_seed * 31 + p * 7) % 100) + 27);
      if (p == n - 1) begin
        it.frame_is_mgmt = ($urandom_range(9) != 0);
        it.signal_length = ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) :
                           12'($urandom_range(40, 300));
      end
      send_item(it, 1'b0, none);
    end
  endtask

  task automatic write_scan(logic v);
    // Let a trailing table walk finish before touching the register.
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    scan_on = v;
  endtask

  sniff_req_t  dir_item [10];
  bit          dir_chk [10];
  sniff_rsp_t  dir_rsp [10];
  logic [47:0] mac_pool [6];

  initial begin
    sniff_req_t it;
    sniff_rsp_t none;
    bit paused;
    bit scan_off_done;
    bit scan_on_done;
    none = '0;
    paused = 1'b0;
    scan_off_done = 1'b0;
    scan_on_done = 1'b0;
    req.valid = 1'b0;
    req.opcode = OP_BYTE;
    req.data_byte = '0;
    req.last_byte = 1'b0;
    req.frame_is_mgmt = 1'b0;
    req.signal_length = '0;
    req.rx_channel = '0;
    req.rx_rssi = '0;
    req.read_index = '0;
    req.read_ssid_pos = '0;
    scan_on = 1'b0;
    tbl_count = 0;
    frame_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reads on an empty table, ignored frame ends, nop and clear.
    for (int k = 0; k < 10; k++) begin
      dir_item[k] = '0;
      dir_chk[k] = 1'b1;
      dir_rsp[k] = '0;
    end
    dir_item[0].opcode = OP_READ;
    dir_item[0].read_index = 6'd0;
    dir_rsp[0].status = ST_NO_ENTRY;
    dir_item[1].opcode = OP_READ;
    dir_item[1].read_index = 6'd63;
    dir_item[1].read_ssid_pos = 5'd31;
    dir_rsp[1].status = ST_NO_ENTRY;
    dir_rsp[1].entry_slot = 6'd63;
    dir_item[2].opcode = OP_NONE;
    dir_chk[2] = 1'b0;
    dir_item[3].opcode = OP_CLEAR;
    dir_chk[3] = 1'b0;
    // one-byte beacon with scan off: ignored
    dir_item[4].data_byte = 8'h80;
    dir_item[4].last_byte = 1'b1;
    dir_item[4].frame_is_mgmt = 1'b1;
    dir_item[4].signal_length = 12'hFFF;
    dir_item[4].rx_rssi = 8'sh7F;
    dir_item[5].data_byte = 8'hFF;
    dir_item[5].last_byte = 1'b1;
    dir_item[5].rx_channel = 4'hF;
    dir_item[5].rx_rssi = -8'sd128;
    for (int k = 0; k < 6; k++) send_item(dir_item[k], dir_chk[k], dir_rsp[k]);

    write_scan(1'b1);
    for (int k = 0; k < 6; k++) mac_pool[k] = 48'({$urandom, $urandom});
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    // Extremes with scan on: short frames, long SSID, saturating length, dups.
    send_frame(40, TYPE_BEACON, mac_pool[1], 255, 1);
    send_frame(40, TYPE_BEACON, mac_pool[1], 255, 1);
    send_frame(30, TYPE_PROBE, mac_pool[0], 0, 2);
    send_frame(70, TYPE_PROBE, mac_pool[0], 32, 3);
    send_frame(5, TYPE_PROBE, mac_pool[2], 9, 3);
    send_frame(20, 8'h11, mac_pool[2], 9, 3);
    it = byte_item(8'h00, 1'b0);
    it.opcode = OP_READ;
    it.read_ssid_pos = 5'd31;
    for (int k = 0; k < 3; k++) begin
      it.read_index = 6'(k);
      send_item(it, 1'b0, none);
    end
    send_frame(120, TYPE_BEACON, mac_pool[3], 12, 4);

    // Random phase: mostly well-formed frames from a small pool, some noise.
    for (int n = 0; n < 700; ) begin
      int pick;
      int len;
      pick = $urandom_range(99);
      idle_pct = (n > 200 && n < 320) ? 0 : 13;
      if (!paused && n >= 350) begin
        // hold off until every result is back
        paused = 1'b1;
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      if (!scan_off_done && n >= 420) begin
        scan_off_done = 1'b1;
        write_scan(1'b0);
      end
      if (!scan_on_done && n >= 500) begin
        scan_on_done = 1'b1;
        write_scan(1'b1);
      end
      if (pick < 55) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(40, 75);
        send_frame(len, $urandom_range(1) ? TYPE_BEACON : TYPE_PROBE,
                   mac_pool[$urandom_range(5)], $urandom_range(0, 40), $urandom_range(5));
        n += len;
      end else begin
        it = byte_item(8'($urandom_range(255)), 1'b0);
        it.read_index = 6'($urandom_range(63));
        it.read_ssid_pos = 5'($urandom_range(31));
        if (pick < 90) it.opcode = OP_READ;
        else if (pick < 93) it.opcode = OP_CLEAR;
        else if (pick < 96) it.opcode = OP_NONE;
        else it.last_byte = 1'b1;
        send_item(it, 1'b0, none);
        n++;
      end
    end

    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
